FILE: rtl/bact_pkg.sv
// Shared types, command and register codes, and widths for the buffer allocation tracker.
package bact_pkg;

    localparam int CMD_W     = 3;
    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 32;
    localparam int CYC_W     = 48;
    localparam int CAP_W     = 32;
    localparam int BCNT_W    = 5;
    localparam int GRAN_W    = 17;
    localparam int BUSY_W    = 8;
    localparam int BANKSEL_W = 4;
    localparam int CNFL_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int DIV_W     = 32;

    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_MAX_BANKS     = 16;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEALLOC = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BANK_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRANULE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_READ_BUSY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_BUSY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_ONLY   = 3'd5;

    localparam logic [CAP_W-1:0]  RST_CAPACITY   = 32'd65536;
    localparam logic [BCNT_W-1:0] RST_BANK_COUNT = 5'd1;
    localparam logic [GRAN_W-1:0] RST_GRANULE    = 17'd64;
    localparam logic [BUSY_W-1:0] RST_READ_BUSY  = 8'd1;
    localparam logic [BUSY_W-1:0] RST_WRITE_BUSY = 8'd1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] block_addr;
        logic [SIZE_W-1:0] block_size;
        logic [CYC_W-1:0]  cycle_now;
    } t_in_item;

    typedef struct packed {
        logic                 ok;
        logic                 was_present;
        logic                 write_allowed;
        logic                 bank_conflict;
        logic [BANKSEL_W-1:0] bank_sel;
        logic [CAP_W-1:0]     free_bytes;
        logic [CNFL_W-1:0]    conflict_total;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] wdata;
    } t_cfg_wr;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [GRAN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quot;
        logic [GRAN_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } t_tbl_entry;

    typedef struct packed {
        logic scan_start;
        logic wr_en;
        logic clr_en;
    } t_tbl_cmd;

    typedef struct packed {
        logic              done;
        logic              hit;
        logic              free_found;
        logic [SIZE_W-1:0] hit_size;
    } t_tbl_stat;

endpackage

FILE: rtl/bact_chan_if.sv
// Valid/ready channel interface carrying one payload of a given type.
interface bact_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/buffer_allocation_bank_conflict_tracker_top.sv
// Top level: buffer allocation table with bank conflict tracking and its sequencer.
// Sequence per input transaction: address / granule and then quotient mod bank count on
// the shared divider, a sequential table scan over its single read port, then the EXEC
// and FIN update states. One transaction is in flight at a time: a new input is taken
// only in idle, and a held result delays the next.
// Reset (synchronous, active low) empties the table, clears occupancy, cycle, bank busy
// times and conflict count, and loads the configuration reset values.
module buffer_allocation_bank_conflict_tracker_top
    import bact_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int MAX_BANKS     = DEF_MAX_BANKS
) (
    input logic         i_clk,
    input logic         i_rst_n,
    bact_chan_if.sink   i_in,
    bact_chan_if.source o_out,
    bact_chan_if.sink   i_cfg
);
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int BANK_W = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV1 = 3'd1;  // addr / granule
    localparam logic [2:0] ST_DIV2 = 3'd2;  // quotient mod bank count
    localparam logic [2:0] ST_SCAN = 3'd3;  // table lookup
    localparam logic [2:0] ST_EXEC = 3'd4;  // apply command to state
    localparam logic [2:0] ST_FIN  = 3'd5;  // form result transaction

    // configuration registers
    logic [CAP_W-1:0]  r_cap;
    logic [BCNT_W-1:0] r_bcnt;
    logic [GRAN_W-1:0] r_gran;
    logic [BUSY_W-1:0] r_rbusy;
    logic [BUSY_W-1:0] r_wbusy;
    logic              r_ro;

    // control and state
    logic [2:0]        r_state;
    logic [2:0]        n_state;
    t_in_item          r_item;
    logic [BANK_W-1:0] r_bank;
    logic [CAP_W-1:0]  r_occ;
    logic [CYC_W-1:0]  r_cur;
    logic [CNFL_W-1:0] r_cc;
    logic              r_ok;
    logic              r_present;
    logic              r_wallow;
    logic              r_conflict;
    t_out_item         r_out;
    logic              r_out_valid;

    // sub-unit connections
    t_div_req          div_req;
    t_div_rsp          div_rsp;
    t_tbl_cmd          tbl_cmd;
    t_tbl_stat         tbl_stat;
    logic [IDX_W-1:0]  hit_idx;
    logic [IDX_W-1:0]  free_idx;
    logic [CYC_W-1:0]  bank_free_at;
    logic              bank_wr;

    // datapath
    logic              in_acc;
    logic [BCNT_W-1:0] banks_use;
    logic              multi_bank;
    logic [GRAN_W-1:0] gran_eff;
    logic [CAP_W:0]    fit_sum;
    logic              fits;
    logic              alloc_ok;
    logic              do_alloc;
    logic              do_free;
    logic              is_access;
    logic [BUSY_W-1:0] busy;
    logic [CYC_W:0]    until_sum;
    logic [CYC_W-1:0]  until_sat;
    logic              conflict_now;
    logic              ok_now;
    logic              out_load;
    logic [CAP_W-1:0]  free_now;

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= RST_CAPACITY;
            r_bcnt  <= RST_BANK_COUNT;
            r_gran  <= RST_GRANULE;
            r_rbusy <= RST_READ_BUSY;
            r_wbusy <= RST_WRITE_BUSY;
            r_ro    <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.data.index)
                REG_CAPACITY:   r_cap   <= i_cfg.data.wdata[CAP_W-1:0];
                REG_BANK_COUNT: r_bcnt  <= i_cfg.data.wdata[BCNT_W-1:0];
                REG_GRANULE:    r_gran  <= i_cfg.data.wdata[GRAN_W-1:0];
                REG_READ_BUSY:  r_rbusy <= i_cfg.data.wdata[BUSY_W-1:0];
                REG_WRITE_BUSY: r_wbusy <= i_cfg.data.wdata[BUSY_W-1:0];
                REG_READ_ONLY:  r_ro    <= i_cfg.data.wdata[0];
                default: ;
            endcase
        end
    end

    // clamp bank count to 1..MAX_BANKS, granule zero acts as one
    always_comb begin
        if (r_bcnt == '0) begin
            banks_use = BCNT_W'(1);
        end else if (int'(r_bcnt) > MAX_BANKS) begin
            banks_use = BCNT_W'(MAX_BANKS);
        end else begin
            banks_use = r_bcnt;
        end
    end
    assign multi_bank = (banks_use > BCNT_W'(1));
    assign gran_eff   = (r_gran == '0) ? GRAN_W'(1) : r_gran;

    // shared divider: first pass addr / granule, second pass quotient mod banks
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = i_in.data.block_addr;
        div_req.divisor  = gran_eff;
        if (r_state == ST_IDLE) begin
            div_req.start = in_acc;
        end else if (r_state == ST_DIV1) begin
            div_req.start    = div_rsp.done;
            div_req.dividend = div_rsp.quot;
            div_req.divisor  = GRAN_W'(banks_use);
        end
    end

    bact_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // command decode against the scan result
    assign fit_sum   = {1'b0, r_occ} + {1'b0, r_item.block_size};
    assign fits      = (fit_sum <= {1'b0, r_cap});
    assign alloc_ok  = fits && !tbl_stat.hit && tbl_stat.free_found;
    assign do_alloc  = alloc_ok && ((r_item.cmd == CMD_ALLOC) || (r_item.cmd == CMD_WRITE));
    assign do_free   = (r_item.cmd == CMD_DEALLOC) && tbl_stat.hit;
    assign is_access = (r_item.cmd == CMD_READ) || (r_item.cmd == CMD_WRITE);
    assign busy      = (r_item.cmd == CMD_WRITE) ? r_wbusy : r_rbusy;

    // bank busy-until time saturates at the top of the cycle range
    assign until_sum    = {1'b0, r_cur} + (CYC_W + 1)'(busy);
    assign until_sat    = until_sum[CYC_W] ? '1 : until_sum[CYC_W-1:0];
    assign conflict_now = is_access && multi_bank && (r_cur < bank_free_at);
    assign bank_wr      = (r_state == ST_EXEC) && is_access && multi_bank;

    always_comb begin
        unique case (r_item.cmd)
            CMD_ALLOC:   ok_now = alloc_ok;
            CMD_DEALLOC: ok_now = tbl_stat.hit;
            CMD_WRITE:   ok_now = do_alloc;
            default:     ok_now = 1'b0;
        endcase
    end

    assign tbl_cmd.scan_start = (r_state == ST_DIV2) && div_rsp.done;
    assign tbl_cmd.wr_en      = (r_state == ST_EXEC) && do_alloc;
    assign tbl_cmd.clr_en     = (r_state == ST_EXEC) && do_free;

    bact_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (tbl_cmd),
        .i_key      (r_item.block_addr),
        .i_wr_idx   (free_idx),
        .i_wr_addr  (r_item.block_addr),
        .i_wr_size  (r_item.block_size),
        .i_clr_idx  (hit_idx),
        .o_stat     (tbl_stat),
        .o_hit_idx  (hit_idx),
        .o_free_idx (free_idx)
    );

    bact_bank #(
        .MAX_BANKS (MAX_BANKS)
    ) u_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_idx     (r_bank),
        .i_wr_en   (bank_wr),
        .i_wr_data (until_sat),
        .o_rd_data (bank_free_at)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc) n_state = ST_DIV1;
            ST_DIV1: if (div_rsp.done) n_state = ST_DIV2;
            ST_DIV2: if (div_rsp.done) n_state = ST_SCAN;
            ST_SCAN: if (tbl_stat.done) n_state = ST_EXEC;
            ST_EXEC: n_state = ST_FIN;
            ST_FIN:  if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // result register: hold until the sink takes it
    assign out_load = (r_state == ST_FIN) && (!r_out_valid || o_out.ready);
    assign free_now = (r_cap > r_occ) ? (r_cap - r_occ) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_cur       <= '0;
            r_cc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EXEC) begin
                if (do_alloc) begin
                    r_occ <= fit_sum[CAP_W-1:0];
                end else if (do_free) begin
                    r_occ <= (r_occ >= tbl_stat.hit_size) ? (r_occ - tbl_stat.hit_size) : '0;
                end
                if (r_item.cmd == CMD_TICK) begin
                    r_cur <= r_item.cycle_now;
                end
                if (conflict_now && (r_cc != '1)) begin
                    r_cc <= r_cc + 1'b1;
                end
            end
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in.data;
        end
        if ((r_state == ST_DIV2) && div_rsp.done) begin
            r_bank <= div_rsp.rem[BANK_W-1:0];
        end
        if (r_state == ST_EXEC) begin
            r_ok       <= ok_now;
            r_present  <= tbl_stat.hit;
            r_wallow   <= fits && !r_ro;
            r_conflict <= conflict_now;
        end
        if (out_load) begin
            r_out.ok             <= r_ok;
            r_out.was_present    <= r_present;
            r_out.write_allowed  <= r_wallow;
            r_out.bank_conflict  <= r_conflict;
            r_out.bank_sel       <= BANKSEL_W'(r_bank);
            r_out.free_bytes     <= free_now;
            r_out.conflict_total <= r_cc;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
endmodule

FILE: rtl/bact_div.sv
// Shared restoring divider: one quotient bit per cycle.
module bact_div
    import bact_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int STEP_W = $clog2(DIV_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIV_W-1:0]  r_q;
    logic [GRAN_W-1:0] r_r;
    logic [GRAN_W-1:0] r_d;

    logic [GRAN_W:0] shifted;
    logic [GRAN_W:0] diff;
    logic            take;

    assign shifted = {r_r, r_q[DIV_W-1]};
    assign diff    = shifted - {1'b0, r_d};
    assign take    = shifted >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q <= i_req.dividend;
            r_r <= '0;
            r_d <= i_req.divisor;
        end else if (r_busy) begin
            r_q <= {r_q[DIV_W-2:0], take};
            r_r <= take ? diff[GRAN_W-1:0] : shifted[GRAN_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r;
endmodule

FILE: rtl/bact_table.sv
// Block table: address/size memory, valid bits and a sequential lookup scan.
module bact_table
    import bact_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tbl_cmd          i_cmd,
    input  logic [ADDR_W-1:0] i_key,
    input  logic [IDX_W-1:0]  i_wr_idx,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [SIZE_W-1:0] i_wr_size,
    input  logic [IDX_W-1:0]  i_clr_idx,
    output t_tbl_stat         o_stat,
    output logic [IDX_W-1:0]  o_hit_idx,
    output logic [IDX_W-1:0]  o_free_idx
);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(TABLE_ENTRIES);

    t_tbl_entry r_mem [TABLE_ENTRIES];
    t_tbl_entry r_rd_entry;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic                     r_active;
    logic                     r_pend;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_rd_vld;
    logic [IDX_W-1:0]         r_rd_idx;
    logic                     r_hit;
    logic [IDX_W-1:0]         r_hit_idx;
    logic [SIZE_W-1:0]        r_hit_size;
    logic                     r_free_found;
    logic [IDX_W-1:0]         r_free_idx;

    logic [IDX_W-1:0] cnt_idx;
    logic             scan_done;

    assign cnt_idx   = r_cnt[IDX_W-1:0];
    assign scan_done = r_active && (r_cnt == LAST) && !r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_active     <= 1'b0;
            r_pend       <= 1'b0;
            r_cnt        <= '0;
            r_rd_vld     <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            if (i_cmd.wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_cmd.clr_en) begin
                r_valid[i_clr_idx] <= 1'b0;
            end
            if (i_cmd.scan_start) begin
                r_active     <= 1'b1;
                r_cnt        <= '0;
                r_pend       <= 1'b0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
            end else if (r_active) begin
                // issue one entry read per cycle
                if (r_cnt != LAST) begin
                    r_cnt    <= r_cnt + 1'b1;
                    r_pend   <= 1'b1;
                    r_rd_vld <= r_valid[cnt_idx];
                    r_rd_idx <= cnt_idx;
                end else begin
                    r_pend <= 1'b0;
                end
                // compare the entry read in the previous cycle
                if (r_pend) begin
                    if (r_rd_vld && (r_rd_entry.addr == i_key) && !r_hit) begin
                        r_hit      <= 1'b1;
                        r_hit_idx  <= r_rd_idx;
                        r_hit_size <= r_rd_entry.size;
                    end
                    if (!r_rd_vld && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_rd_idx;
                    end
                end
                if (scan_done) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_idx] <= '{addr: i_wr_addr, size: i_wr_size};
        end
        r_rd_entry <= r_mem[cnt_idx];
    end

    assign o_stat.done       = scan_done;
    assign o_stat.hit        = r_hit;
    assign o_stat.free_found = r_free_found;
    assign o_stat.hit_size   = r_hit_size;
    assign o_hit_idx         = r_hit_idx;
    assign o_free_idx        = r_free_idx;
endmodule

FILE: rtl/bact_bank.sv
// Per-bank busy-until cycle store with valid bits standing in for the reset value.
module bact_bank
    import bact_pkg::*;
#(
    parameter int MAX_BANKS = DEF_MAX_BANKS,
    localparam int BANK_W = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BANK_W-1:0] i_idx,
    input  logic              i_wr_en,
    input  logic [CYC_W-1:0]  i_wr_data,
    output logic [CYC_W-1:0]  o_rd_data
);
    logic [CYC_W-1:0]     r_mem [MAX_BANKS];
    logic [CYC_W-1:0]     r_rd;
    logic [MAX_BANKS-1:0] r_written;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_rd_vld <= r_written[i_idx];
            if (i_wr_en) begin
                r_written[i_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_idx] <= i_wr_data;
        end
        r_rd <= r_mem[i_idx];
    end

    // a bank never written reads as free since cycle zero
    assign o_rd_data = r_rd_vld ? r_rd : '0;
endmodule
